// ===== rtl/snc_pkg.sv =====
// Shared types, constants and the volume table for the note stream converter.
// Used by snc_alu, snc_core, snc_obuf and the top level sound_note_stream_converter.
package snc_pkg;

    localparam int CH_W    = 2;
    localparam int BYTE_W  = 8;
    localparam int BEAT_W  = 32;
    localparam int DIV_W   = 10;
    localparam int NUM_W   = 17;
    localparam int FREQ_W  = 16;
    localparam int CNT_W   = 5;
    localparam int TDATA_W = 48;
    localparam int TUSER_W = 3;

    localparam logic [NUM_W-1:0]  CLOCK_NUM   = 17'd111860;
    localparam logic [BEAT_W-1:0] RATE_MULT   = 32'd176026;
    localparam logic [CNT_W-1:0]  DIV_STEPS   = 5'd17;
    localparam logic [CNT_W-1:0]  MUL_STEPS   = 5'd16;
    localparam logic [BYTE_W-1:0] END_BYTE    = 8'hFF;
    localparam logic [3:0]        SILENT_VOL  = 4'hF;

    typedef enum logic [0:0] {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } alu_op_t;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic [CH_W-1:0]   channel_index;
        logic              last_of_run;
        logic              sound_done;
        logic [BEAT_W-1:0] total_beats;
        logic              periodic_pass_needed;
    } result_t;

    // Handover of finished results from the core to the output buffer.
    typedef struct packed {
        logic valid;
        logic two;
    } push_t;

    function automatic result_t make_result(input logic [BYTE_W-1:0] b,
                                            input logic [CH_W-1:0] ch,
                                            input logic last);
        result_t r;
        r.out_byte             = b;
        r.channel_index        = ch;
        r.last_of_run          = last;
        r.sound_done           = 1'b0;
        r.total_beats          = '0;
        r.periodic_pass_needed = 1'b0;
        return r;
    endfunction

    function automatic logic [BYTE_W-1:0] vol_map(input logic [3:0] n);
        logic [BYTE_W-1:0] v;
        unique case (n)
            4'd0:  v = 8'd63;
            4'd1:  v = 8'd59;
            4'd2:  v = 8'd55;
            4'd3:  v = 8'd51;
            4'd4:  v = 8'd47;
            4'd5:  v = 8'd43;
            4'd6:  v = 8'd39;
            4'd7:  v = 8'd35;
            4'd8:  v = 8'd31;
            4'd9:  v = 8'd27;
            4'd10: v = 8'd23;
            4'd11: v = 8'd19;
            4'd12: v = 8'd15;
            4'd13: v = 8'd11;
            4'd14: v = 8'd7;
            default: v = 8'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/snc_alu.sv =====
// Shared 32-bit add/subtract unit of the note stream converter.
// Depends on snc_pkg for the operation code.
module snc_alu import snc_pkg::*; (
    input  alu_op_t           op_i,
    input  logic [BEAT_W-1:0] a_i,
    input  logic [BEAT_W-1:0] b_i,
    output logic [BEAT_W-1:0] res_o,
    output logic              carry_o
);

    logic [BEAT_W:0] sum;

    always_comb begin
        unique case (op_i)
            ALU_ADD: sum = {1'b0, a_i} + {1'b0, b_i};
            ALU_SUB: sum = {1'b0, a_i} - {1'b0, b_i};
        endcase
    end

    // For a subtraction the top bit is the borrow, set when a_i < b_i.
    assign res_o   = sum[BEAT_W-1:0];
    assign carry_o = sum[BEAT_W];

endmodule

// ===== rtl/snc_core.sv =====
// Sequencer and state of the note stream converter: decodes note bytes and
// drives the shared adder for sums, compares, division and multiplication.
// Depends on snc_pkg and snc_alu.
module snc_core import snc_pkg::*; #(
    parameter int NUM_CHANNELS = 4
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid_i,
    output logic                in_ready_o,
    input  logic [BYTE_W-1:0]   in_byte_i,
    input  logic                obuf_empty_i,
    output push_t               push_o,
    output result_t [1:0]       res_o
);

    localparam logic [CH_W-1:0] LAST_CH = CH_W'(NUM_CHANNELS - 1);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_SAT  = 6'b000010,
        ST_MAXC = 6'b000100,
        ST_DIV  = 6'b001000,
        ST_MUL  = 6'b010000,
        ST_WAIT = 6'b100000
    } state_t;

    state_t              state_reg, state_next;
    logic [2:0]          pos_reg, pos_next;
    logic [CH_W-1:0]     chan_reg, chan_next;
    logic [BYTE_W-1:0]   held_reg, held_next;
    logic [BEAT_W-1:0]   sum_reg, sum_next;
    logic [BEAT_W-1:0]   max_reg, max_next;
    logic                per_reg, per_next;
    logic                aud_reg, aud_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;

    logic [DIV_W-1:0]    d_reg, d_next;
    logic [DIV_W-1:0]    rem_reg, rem_next;
    logic [NUM_W-1:0]    num_reg, num_next;
    logic [NUM_W-1:0]    quo_reg, quo_next;
    logic [FREQ_W-1:0]   f_reg, f_next;
    logic [BEAT_W-1:0]   mcand_reg, mcand_next;
    logic [BEAT_W-1:0]   acc_reg, acc_next;
    result_t             res0_reg, res0_next;
    result_t             res1_reg, res1_next;
    logic                two_reg, two_next;

    alu_op_t             alu_op;
    logic [BEAT_W-1:0]   alu_a, alu_b, alu_res;
    logic                alu_carry;

    logic [2:0]          pos_eff;
    logic                noise;
    logic [DIV_W-1:0]    d_raw;
    logic [NUM_W:0]      q_inc;
    logic [BEAT_W-1:0]   acc_step;
    logic [BEAT_W-1:0]   new_max;
    push_t               push;

    snc_alu u_alu (
        .op_i    (alu_op),
        .a_i     (alu_a),
        .b_i     (alu_b),
        .res_o   (alu_res),
        .carry_o (alu_carry)
    );

    assign in_ready_o = (state_reg == ST_IDLE);
    assign push_o     = push;
    assign res_o[0]   = res0_reg;
    assign res_o[1]   = res1_reg;

    always_comb begin
        state_next = state_reg;
        pos_next   = pos_reg;
        chan_next  = chan_reg;
        held_next  = held_reg;
        sum_next   = sum_reg;
        max_next   = max_reg;
        per_next   = per_reg;
        aud_next   = aud_reg;
        cnt_next   = cnt_reg;
        d_next     = d_reg;
        rem_next   = rem_reg;
        num_next   = num_reg;
        quo_next   = quo_reg;
        f_next     = f_reg;
        mcand_next = mcand_reg;
        acc_next   = acc_reg;
        res0_next  = res0_reg;
        res1_next  = res1_reg;
        two_next   = two_reg;
        push       = '0;
        alu_op     = ALU_ADD;
        alu_a      = '0;
        alu_b      = '0;
        q_inc      = '0;
        acc_step   = acc_reg;
        new_max    = max_reg;

        pos_eff = (pos_reg > 3'd4) ? 3'd0 : pos_reg;
        noise   = (chan_reg == LAST_CH);
        d_raw   = {held_reg[5:0], in_byte_i[3:0]};

        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid_i) begin
                    unique case (pos_eff)
                        3'd1: begin
                            two_next = 1'b1;
                            if (held_reg == END_BYTE && in_byte_i == END_BYTE) begin
                                res0_next  = make_result(END_BYTE, chan_reg, 1'b0);
                                res1_next  = make_result(END_BYTE, chan_reg, 1'b1);
                                pos_next   = 3'd0;
                                state_next = ST_MAXC;
                            end else begin
                                res0_next  = make_result(held_reg, chan_reg, 1'b0);
                                res1_next  = make_result(in_byte_i, chan_reg, 1'b1);
                                acc_next   = {16'd0, in_byte_i, held_reg};
                                pos_next   = 3'd2;
                                state_next = ST_SAT;
                            end
                        end
                        3'd3: begin
                            pos_next = 3'd4;
                            if (noise) begin
                                if (!in_byte_i[2]) begin
                                    per_next = 1'b1;
                                end
                                res0_next  = make_result(held_reg, chan_reg, 1'b0);
                                res1_next  = make_result(in_byte_i, chan_reg, 1'b1);
                                two_next   = 1'b1;
                                state_next = ST_WAIT;
                            end else begin
                                d_next     = (d_raw == '0) ? DIV_W'(1) : d_raw;
                                rem_next   = '0;
                                num_next   = CLOCK_NUM;
                                quo_next   = '0;
                                cnt_next   = DIV_STEPS - 5'd1;
                                state_next = ST_DIV;
                            end
                        end
                        3'd4: begin
                            if (noise && in_byte_i[3:0] != SILENT_VOL) begin
                                aud_next = 1'b1;
                            end
                            res0_next  = make_result(vol_map(in_byte_i[3:0]), chan_reg, 1'b1);
                            two_next   = 1'b0;
                            pos_next   = 3'd0;
                            state_next = ST_WAIT;
                        end
                        default: begin
                            // First byte of a pair is kept until its partner arrives.
                            held_next = in_byte_i;
                            pos_next  = pos_eff + 3'd1;
                        end
                    endcase
                end
            end
            ST_SAT: begin
                alu_op     = ALU_ADD;
                alu_a      = sum_reg;
                alu_b      = acc_reg;
                sum_next   = alu_carry ? '1 : alu_res;
                state_next = ST_WAIT;
            end
            ST_MAXC: begin
                alu_op  = ALU_SUB;
                alu_a   = max_reg;
                alu_b   = sum_reg;
                new_max = alu_carry ? sum_reg : max_reg;
                if (chan_reg == LAST_CH) begin
                    res1_next.sound_done           = 1'b1;
                    res1_next.total_beats          = new_max;
                    res1_next.periodic_pass_needed = per_reg & aud_reg;
                    pos_next  = '0;
                    chan_next = '0;
                    held_next = '0;
                    sum_next  = '0;
                    max_next  = '0;
                    per_next  = 1'b0;
                    aud_next  = 1'b0;
                end else begin
                    max_next  = new_max;
                    sum_next  = '0;
                    chan_next = chan_reg + CH_W'(1);
                end
                state_next = ST_WAIT;
            end
            ST_DIV: begin
                // One restoring division step: shift in a numerator bit, try to subtract.
                alu_op   = ALU_SUB;
                alu_a    = {21'd0, rem_reg, num_reg[NUM_W-1]};
                alu_b    = {22'd0, d_reg};
                num_next = {num_reg[NUM_W-2:0], 1'b0};
                if (!alu_carry) begin
                    rem_next = alu_res[DIV_W-1:0];
                    quo_next = {quo_reg[NUM_W-2:0], 1'b1};
                end else begin
                    rem_next = {rem_reg[DIV_W-2:0], num_reg[NUM_W-1]};
                    quo_next = {quo_reg[NUM_W-2:0], 1'b0};
                end
                if (cnt_reg == '0) begin
                    q_inc      = {1'b0, quo_next} + 18'd1;
                    f_next     = q_inc[FREQ_W:1];
                    acc_next   = '0;
                    mcand_next = RATE_MULT;
                    cnt_next   = MUL_STEPS - 5'd1;
                    state_next = ST_MUL;
                end else begin
                    cnt_next = cnt_reg - 5'd1;
                end
            end
            ST_MUL: begin
                // Shift-add multiply, one multiplier bit per cycle, kept modulo 2^32.
                alu_op     = ALU_ADD;
                alu_a      = acc_reg;
                alu_b      = mcand_reg;
                acc_step   = f_reg[0] ? alu_res : acc_reg;
                acc_next   = acc_step;
                mcand_next = {mcand_reg[BEAT_W-2:0], 1'b0};
                f_next     = {1'b0, f_reg[FREQ_W-1:1]};
                if (cnt_reg == '0) begin
                    res0_next  = make_result(acc_step[23:16], chan_reg, 1'b0);
                    res1_next  = make_result(acc_step[31:24], chan_reg, 1'b1);
                    two_next   = 1'b1;
                    state_next = ST_WAIT;
                end else begin
                    cnt_next = cnt_reg - 5'd1;
                end
            end
            ST_WAIT: begin
                if (obuf_empty_i) begin
                    push.valid = 1'b1;
                    push.two   = two_reg;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            pos_reg   <= '0;
            chan_reg  <= '0;
            held_reg  <= '0;
            sum_reg   <= '0;
            max_reg   <= '0;
            per_reg   <= 1'b0;
            aud_reg   <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            chan_reg  <= chan_next;
            held_reg  <= held_next;
            sum_reg   <= sum_next;
            max_reg   <= max_next;
            per_reg   <= per_next;
            aud_reg   <= aud_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        d_reg     <= d_next;
        rem_reg   <= rem_next;
        num_reg   <= num_next;
        quo_reg   <= quo_next;
        f_reg     <= f_next;
        mcand_reg <= mcand_next;
        acc_reg   <= acc_next;
        res0_reg  <= res0_next;
        res1_reg  <= res1_next;
        two_reg   <= two_next;
    end

    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= 3'd4)
        else $error("note position left the five-byte note");

    a_div_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (cnt_reg < DIV_STEPS))
        else $error("division step count out of range");

    a_push_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        push.valid |-> obuf_empty_i)
        else $error("results handed over while the output buffer is busy");

endmodule

// ===== rtl/snc_obuf.sv =====
// Two-entry output buffer of the note stream converter; drains results one
// item per cycle on the master stream while m_ready_i is high. Depends on snc_pkg.
module snc_obuf import snc_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  push_t         push_i,
    input  result_t [1:0] res_i,
    output logic          empty_o,
    output logic          m_valid_o,
    input  logic          m_ready_i,
    output result_t       m_res_o
);

    logic [1:0] cnt_reg, cnt_next;
    result_t    slot0_reg, slot0_next;
    result_t    slot1_reg, slot1_next;

    assign empty_o   = (cnt_reg == 2'd0);
    assign m_valid_o = (cnt_reg != 2'd0);
    assign m_res_o   = slot0_reg;

    always_comb begin
        cnt_next   = cnt_reg;
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        if (push_i.valid) begin
            slot0_next = res_i[0];
            slot1_next = res_i[1];
            cnt_next   = push_i.two ? 2'd2 : 2'd1;
        end else if (m_valid_o && m_ready_i) begin
            slot0_next = slot1_reg;
            cnt_next   = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= 2'd2)
        else $error("output buffer holds more than two items");

    a_last_tail: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd1) |-> slot0_reg.last_of_run)
        else $error("final buffered item is not marked last");

    a_push_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        push_i.valid |-> (cnt_reg == 2'd0))
        else $error("load into a non-empty output buffer");

endmodule

// ===== rtl/sound_note_stream_converter.sv =====
// Note stream converter. A byte is taken in only while the core is idle; a held first
// byte of a pair gives no result. Duration bytes pass a saturating add, end markers a
// max compare, tone frequency bytes 17 division and 16 shift-add steps through the one
// shared adder; noise frequency and volume bytes none. All then wait for an empty buffer.
// With m_axis_tready high, results leave a two-entry buffer one per cycle as bytes come in.
// aresetn (synchronous, active low) clears all note state, sums and the buffer.
module sound_note_stream_converter import snc_pkg::*; #(
    parameter int NUM_CHANNELS = 4
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [7:0]         s_axis_tdata,   // [7:0] data_byte
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    // [7:0] out_byte, [39:8] total_beats, [40] periodic_pass_needed, rest zero
    output logic [TDATA_W-1:0] m_axis_tdata,
    // [1:0] channel_index, [2] sound_done
    output logic [TUSER_W-1:0] m_axis_tuser,
    output logic               m_axis_tlast
);

    push_t         push;
    result_t [1:0] res;
    result_t       m_res;
    logic          obuf_empty;

    snc_core #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid_i   (s_axis_tvalid),
        .in_ready_o   (s_axis_tready),
        .in_byte_i    (s_axis_tdata),
        .obuf_empty_i (obuf_empty),
        .push_o       (push),
        .res_o        (res)
    );

    snc_obuf u_obuf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_i    (push),
        .res_i     (res),
        .empty_o   (obuf_empty),
        .m_valid_o (m_axis_tvalid),
        .m_ready_i (m_axis_tready),
        .m_res_o   (m_res)
    );

    assign m_axis_tdata = {7'd0, m_res.periodic_pass_needed, m_res.total_beats,
                           m_res.out_byte};
    assign m_axis_tuser = {m_res.sound_done, m_res.channel_index};
    assign m_axis_tlast = m_res.last_of_run;

endmodule
